### hdl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared constants and helpers for the comma-aware text lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int unsigned LEN_W     = 10;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 10;
    localparam int unsigned RES_MAX   = 3;
    localparam int unsigned RES_CNT_W = 2;

    // hard cap on token length, applied on top of the register
    localparam logic [LEN_W-1:0] TOKEN_LEN_MAX = 10'd1023;

    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 10'd1023;
    localparam logic [BYTE_W-1:0] SEP_RST     = 8'd44;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP     = 1'd1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOT  = 2'd2;

    // bytes with a meaning of their own
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] chr;
        logic              quoted;
        logic              trunc;
    } t_res;

    // bytes up to and including space and the upper half are all skipped
    function automatic logic f_is_skip(input logic [BYTE_W-1:0] b);
        return (b <= CH_SPACE) || b[BYTE_W-1];
    endfunction

endpackage

### hdl/comma_token_lexer_core.sv
// ----------------------------------------------------------------------------
// comma_token_lexer_core
// Byte-stream lexer: skips space, control and upper-half bytes and C comments,
// ends words at a programmable separator byte, and emits token characters and markers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_byte
//  out     | output    | o_out_valid / i_out_stall  | o_out_kind, o_out_char,
//          |           |                            | o_was_quoted,
//          |           |                            | o_was_truncated,
//          |           |                            | o_last_of_run
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// Each byte is lexed in the cycle it is accepted; its zero to three results
// land in a result register and leave one per cycle unless the output
// stalls, so bytes giving at most one result go in at a byte per cycle;
// a byte giving more holds the input while the result register drains.
// Reset (synchronous, active low) returns the lexer to idle between tokens
// and loads the register defaults. The input stalls only while more than
// one result is still waiting, or one is waiting and the output stalls.
//
module comma_token_lexer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ctl_pkg::BYTE_W-1:0]      i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ctl_pkg::KIND_W-1:0]      o_out_kind,
    output logic [ctl_pkg::BYTE_W-1:0]      o_out_char,
    output logic                            o_was_quoted,
    output logic                            o_was_truncated,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_we,
    input  logic [ctl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ctl_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SLASH = 3'd1,
        M_LINE  = 3'd2,
        M_BLOCK = 3'd3,
        M_BSTAR = 3'd4,
        M_WORD  = 3'd5,
        M_QUOTE = 3'd6
    } t_mode;

    typedef struct packed {
        t_mode                            mode;
        logic [ctl_pkg::LEN_W-1:0]        len;
        logic                             drp;
        logic [ctl_pkg::RES_CNT_W-1:0]    cnt;
        ctl_pkg::t_res [ctl_pkg::RES_MAX-1:0] res;
    } t_work;

    t_mode                              r_mode;
    logic [ctl_pkg::LEN_W-1:0]          r_len;
    logic                               r_drp;
    logic [ctl_pkg::LEN_W-1:0]          r_max_len;
    logic [ctl_pkg::BYTE_W-1:0]         r_sep;
    logic [ctl_pkg::RES_CNT_W-1:0]      r_rem;
    ctl_pkg::t_res [ctl_pkg::RES_MAX-1:0] r_res;

    t_work                              n_work;
    logic [ctl_pkg::LEN_W-1:0]          lim;
    logic                               in_acc;
    logic                               out_acc;

    function automatic t_work f_emit(input t_work w, input logic [ctl_pkg::KIND_W-1:0] kind,
                                     input logic [ctl_pkg::BYTE_W-1:0] chr,
                                     input logic quoted, input logic trunc);
        t_work v;
        v = w;
        if (v.cnt < ctl_pkg::RES_CNT_W'(ctl_pkg::RES_MAX)) begin
            v.res[v.cnt].kind   = kind;
            v.res[v.cnt].chr    = chr;
            v.res[v.cnt].quoted = quoted;
            v.res[v.cnt].trunc  = trunc;
            v.cnt               = v.cnt + 1'b1;
        end
        return v;
    endfunction

    function automatic t_work f_start(input t_work w);
        t_work v;
        v     = w;
        v.len = '0;
        v.drp = 1'b0;
        return v;
    endfunction

    // keep the character while under the limit, else flag the drop
    function automatic t_work f_add(input t_work w, input logic [ctl_pkg::BYTE_W-1:0] b,
                                    input logic quoted, input logic [ctl_pkg::LEN_W-1:0] lm);
        t_work v;
        v = w;
        if (v.len < lm) begin
            v.len = v.len + 1'b1;
            v     = f_emit(v, ctl_pkg::KIND_CHAR, b, quoted, 1'b0);
        end else begin
            v.drp = 1'b1;
        end
        return v;
    endfunction

    function automatic t_work f_idle(input t_work w, input logic [ctl_pkg::BYTE_W-1:0] b,
                                     input logic [ctl_pkg::LEN_W-1:0] lm);
        t_work v;
        v = w;
        if (b == ctl_pkg::CH_NUL) begin
            v      = f_emit(v, ctl_pkg::KIND_EOT, ctl_pkg::CH_NUL, 1'b0, 1'b0);
            v.mode = M_IDLE;
        end else if (ctl_pkg::f_is_skip(b)) begin
            v.mode = M_IDLE;
        end else if (b == ctl_pkg::CH_SLASH) begin
            v.mode = M_SLASH;
        end else if (b == ctl_pkg::CH_QUOTE) begin
            v      = f_start(v);
            v.mode = M_QUOTE;
        end else begin
            v      = f_start(v);
            v      = f_add(v, b, 1'b0, lm);
            v.mode = M_WORD;
        end
        return v;
    endfunction

    // the byte that ends a word is lexed again as the first idle byte
    function automatic t_work f_word(input t_work w, input logic [ctl_pkg::BYTE_W-1:0] b,
                                     input logic [ctl_pkg::BYTE_W-1:0] sep,
                                     input logic [ctl_pkg::LEN_W-1:0] lm);
        t_work v;
        v = w;
        if (!ctl_pkg::f_is_skip(b) && (b != sep)) begin
            v = f_add(v, b, 1'b0, lm);
        end else begin
            v      = f_emit(v, ctl_pkg::KIND_END, ctl_pkg::CH_NUL, 1'b0, v.drp);
            v.mode = M_IDLE;
            v      = f_idle(v, b, lm);
        end
        return v;
    endfunction

    assign lim = (ctl_pkg::TOKEN_LEN_MAX < r_max_len) ? ctl_pkg::TOKEN_LEN_MAX : r_max_len;

    always_comb begin
        n_work      = '0;
        n_work.mode = r_mode;
        n_work.len  = r_len;
        n_work.drp  = r_drp;
        unique case (r_mode)
            M_SLASH: begin
                if (i_in_byte == ctl_pkg::CH_SLASH) begin
                    n_work.mode = M_LINE;
                end else if (i_in_byte == ctl_pkg::CH_STAR) begin
                    n_work.mode = M_BSTAR;
                end else begin
                    // lone slash opens a word
                    n_work      = f_start(n_work);
                    n_work      = f_add(n_work, ctl_pkg::CH_SLASH, 1'b0, lim);
                    n_work.mode = M_WORD;
                    n_work      = f_word(n_work, i_in_byte, r_sep, lim);
                end
            end
            M_LINE: begin
                if (i_in_byte == ctl_pkg::CH_NUL) begin
                    n_work = f_idle(n_work, i_in_byte, lim);
                end else if (i_in_byte == ctl_pkg::CH_NL) begin
                    n_work.mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (i_in_byte == ctl_pkg::CH_NUL) begin
                    n_work = f_idle(n_work, i_in_byte, lim);
                end else if (i_in_byte == ctl_pkg::CH_STAR) begin
                    n_work.mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (i_in_byte == ctl_pkg::CH_NUL) begin
                    n_work = f_idle(n_work, i_in_byte, lim);
                end else if (i_in_byte == ctl_pkg::CH_SLASH) begin
                    n_work.mode = M_IDLE;
                end else if (i_in_byte != ctl_pkg::CH_STAR) begin
                    n_work.mode = M_BLOCK;
                end
            end
            M_WORD: begin
                n_work = f_word(n_work, i_in_byte, r_sep, lim);
            end
            M_QUOTE: begin
                if (i_in_byte == ctl_pkg::CH_QUOTE) begin
                    n_work = f_emit(n_work, ctl_pkg::KIND_END, ctl_pkg::CH_NUL, 1'b1,
                                    n_work.drp);
                    n_work.mode = M_IDLE;
                end else if (i_in_byte == ctl_pkg::CH_NUL) begin
                    n_work = f_emit(n_work, ctl_pkg::KIND_END, ctl_pkg::CH_NUL, 1'b1,
                                    n_work.drp);
                    n_work.mode = M_IDLE;
                    n_work      = f_idle(n_work, i_in_byte, lim);
                end else begin
                    n_work = f_add(n_work, i_in_byte, 1'b1, lim);
                end
            end
            default: begin
                n_work.mode = M_IDLE;
                n_work      = f_idle(n_work, i_in_byte, lim);
            end
        endcase
    end

    // take a new byte once the last waiting result leaves
    assign o_in_stall = (r_rem > 2'd1) || ((r_rem == 2'd1) && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_len     <= '0;
            r_drp     <= 1'b0;
            r_rem     <= '0;
            r_max_len <= ctl_pkg::MAX_LEN_RST;
            r_sep     <= ctl_pkg::SEP_RST;
        end else begin
            if (in_acc) begin
                r_mode <= n_work.mode;
                r_len  <= n_work.len;
                r_drp  <= n_work.drp;
                r_rem  <= n_work.cnt;
            end else if (out_acc) begin
                r_rem <= r_rem - 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ctl_pkg::REG_MAX_LEN: r_max_len <= i_cfg_wdata[ctl_pkg::LEN_W-1:0];
                    ctl_pkg::REG_SEP:     r_sep     <= i_cfg_wdata[ctl_pkg::BYTE_W-1:0];
                    default:              r_sep     <= r_sep;
                endcase
            end
        end
    end

    // result words: load a fresh batch, or advance by one on each take
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_work.res;
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_out_valid     = (r_rem != '0);
    assign o_out_kind      = r_res[0].kind;
    assign o_out_char      = r_res[0].chr;
    assign o_was_quoted    = r_res[0].quoted;
    assign o_was_truncated = r_res[0].trunc;
    assign o_last_of_run   = (r_rem == 2'd1);

endmodule
